// ----- design/paired_stream_id_allocator_defines.svh -----
// Assertion macros shared by the stream ID allocator RTL.
`ifndef PAIRED_STREAM_ID_ALLOCATOR_DEFINES_SVH
`define PAIRED_STREAM_ID_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define PSIA_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define PSIA_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/psia_pkg.sv -----
// Shared types and constants for the paired stream ID allocator.
`default_nettype none
package psia_pkg;

   localparam int MODE_W      = 3;
   localparam int ID_W        = 6;
   localparam int TAG_W       = 16;
   localparam int STATUS_W    = 2;
   localparam int CNT_W       = 7;
   localparam int CSR_IDX_W   = 1;
   localparam int GRP_W       = 8;
   localparam int GRP_SEL_W   = $clog2(GRP_W);
   localparam int QUEUE_DEPTH = 2;
   localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
   localparam int Q_FILL_W    = $clog2(QUEUE_DEPTH + 1);

   localparam logic [MODE_W-1:0] MODE_RES_PAIR = 3'd0;
   localparam logic [MODE_W-1:0] MODE_RES_OUT  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_REL_PAIR = 3'd2;
   localparam logic [MODE_W-1:0] MODE_REL_OUT  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_QUERY    = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_IN_COUNT  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_COUNT = 1'd1;

   localparam logic [CNT_W-1:0] CNT_RESET = 7'd64;

   typedef enum logic [2:0] {
      OP_RES_PAIR,
      OP_RES_OUT,
      OP_REL_PAIR,
      OP_REL_OUT,
      OP_QUERY,
      OP_NOP
   } op_type;

   typedef struct packed {
      op_type            op;
      logic              range_err;
      logic [ID_W-1:0]   id;
      logic [TAG_W-1:0]  tag;
   } cmd_type;

   typedef struct packed {
      logic [CNT_W-1:0] nin;
      logic [CNT_W-1:0] nout;
      logic [CNT_W-1:0] npair;
   } limits_type;

   typedef enum logic {
      BK_IDLE,
      BK_EXEC
   } back_state_type;

endpackage
`default_nettype wire

// ----- design/psia_channels.sv -----
// Request and response channel interfaces of the allocator.
`default_nettype none
interface psia_req_if;
   logic                          valid;
   logic                          ready;
   logic [psia_pkg::MODE_W-1:0]   mode;
   logic [psia_pkg::ID_W-1:0]     stream_id;
   logic [psia_pkg::TAG_W-1:0]    owner_tag;

   modport source (output valid, mode, stream_id, owner_tag, input ready);
   modport sink   (input valid, mode, stream_id, owner_tag, output ready);
endinterface

interface psia_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [psia_pkg::STATUS_W-1:0] status;
   logic [psia_pkg::ID_W-1:0]     granted_id;
   logic [psia_pkg::TAG_W-1:0]    stored_tag;
   logic                          in_use;

   modport source (output valid, status, granted_id, stored_tag, in_use, input ready);
   modport sink   (input valid, status, granted_id, stored_tag, in_use, output ready);
endinterface
`default_nettype wire

// ----- design/psia_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module psia_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule
`default_nettype wire

// ----- design/psia_front.sv -----
// Front end: takes request items, decodes the mode and checks the ID range.
`default_nettype none
module psia_front (
   input  wire psia_pkg::limits_type lim,
   psia_req_if.sink                  req_bus,
   input  wire logic                 q_full,
   output logic                      push,
   output psia_pkg::cmd_type         push_cmd
);

   logic [psia_pkg::CNT_W-1:0] id_ext;

   always_comb begin
      req_bus.ready = !q_full;
      push          = req_bus.valid && !q_full;
      id_ext        = psia_pkg::CNT_W'(req_bus.stream_id);

      push_cmd.id        = req_bus.stream_id;
      push_cmd.tag       = req_bus.owner_tag;
      push_cmd.range_err = 1'b0;
      push_cmd.op        = psia_pkg::OP_NOP;

      case (req_bus.mode)
         psia_pkg::MODE_RES_PAIR: push_cmd.op = psia_pkg::OP_RES_PAIR;
         psia_pkg::MODE_RES_OUT:  push_cmd.op = psia_pkg::OP_RES_OUT;
         psia_pkg::MODE_REL_PAIR: begin
            push_cmd.op        = psia_pkg::OP_REL_PAIR;
            push_cmd.range_err = id_ext >= lim.npair;
         end
         psia_pkg::MODE_REL_OUT: begin
            push_cmd.op        = psia_pkg::OP_REL_OUT;
            push_cmd.range_err = id_ext >= lim.npair;
         end
         psia_pkg::MODE_QUERY: begin
            push_cmd.op        = psia_pkg::OP_QUERY;
            push_cmd.range_err = id_ext >= lim.nin;
         end
         default: push_cmd.op = psia_pkg::OP_NOP;
      endcase
   end

endmodule
`default_nettype wire

// ----- design/psia_queue.sv -----
// Short command queue between the front end and the back end.
`default_nettype none
module psia_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire psia_pkg::cmd_type push_cmd,
   input  wire logic              pop,
   output psia_pkg::cmd_type      head_cmd,
   output logic                   full,
   output logic                   empty
);

   psia_pkg::cmd_type              slot_ff [psia_pkg::QUEUE_DEPTH];
   logic [psia_pkg::Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [psia_pkg::Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [psia_pkg::Q_FILL_W-1:0]  fill_ff, fill_in;

   always_comb begin
      full      = fill_ff == psia_pkg::Q_FILL_W'(psia_pkg::QUEUE_DEPTH);
      empty     = fill_ff == '0;
      head_cmd  = slot_ff[rd_ptr_ff];
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff + psia_pkg::Q_FILL_W'(push) - psia_pkg::Q_FILL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

// ----- design/psia_back.sv -----
// Back end: usage bitmaps, two-step lowest-free search, tag store, result register.
`default_nettype none
module psia_back #(
   parameter int MAX_STREAMS = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire psia_pkg::limits_type lim,
   input  wire psia_pkg::cmd_type    head_cmd,
   input  wire logic                 q_empty,
   output logic                      pop,
   psia_rsp_if.source                rsp_bus
);

   localparam int MAP_LIMIT = 1 << psia_pkg::CNT_W;
   localparam int TAG_LIMIT = 1 << psia_pkg::ID_W;
   localparam int MAP_DEPTH = (MAX_STREAMS < MAP_LIMIT) ? MAX_STREAMS : MAP_LIMIT;
   localparam int NGRP      = (MAP_DEPTH + psia_pkg::GRP_W - 1) / psia_pkg::GRP_W;
   localparam int PAD_W     = NGRP * psia_pkg::GRP_W;
   localparam int GRP_IW    = (NGRP > 1) ? $clog2(NGRP) : 1;
   localparam int IDX_W     = GRP_IW + psia_pkg::GRP_SEL_W;
   localparam int TAG_DEPTH = (MAP_DEPTH < TAG_LIMIT) ? MAP_DEPTH : TAG_LIMIT;
   localparam int TAG_AW    = $clog2(TAG_DEPTH);

   psia_pkg::back_state_type state_ff, state_in;
   psia_pkg::cmd_type        cmd_ff;

   logic [MAP_DEPTH-1:0] in_map_ff, in_map_in;
   logic [MAP_DEPTH-1:0] out_map_ff, out_map_in;

   logic [NGRP-1:0]                           grp_any_ff, grp_any_in;
   logic [NGRP-1:0][psia_pkg::GRP_SEL_W-1:0]  grp_first_ff, grp_first_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [psia_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [psia_pkg::ID_W-1:0]     rsp_id_ff, rsp_id_in;
   logic [psia_pkg::TAG_W-1:0]    rsp_tag_ff, rsp_tag_in;
   logic                          rsp_used_ff, rsp_used_in;

   logic                       fire;
   logic [PAD_W-1:0]           in_pad, out_pad, free_vec;
   logic [psia_pkg::CNT_W-1:0] limit;
   logic                       found;
   logic [GRP_IW-1:0]          sel_g;
   logic [IDX_W-1:0]           grant_idx;
   logic [IDX_W-1:0]           mid;
   logic                       tag_we;
   logic [psia_pkg::TAG_W-1:0] tag_rd_data;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         psia_pkg::BK_IDLE: if (!q_empty) state_in = psia_pkg::BK_EXEC;
         psia_pkg::BK_EXEC: if (fire) state_in = psia_pkg::BK_IDLE;
         default:           state_in = psia_pkg::BK_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      pop  = 1'b0;
      fire = 1'b0;
      case (state_ff)
         psia_pkg::BK_IDLE: pop  = !q_empty;
         psia_pkg::BK_EXEC: fire = !rsp_valid_ff || rsp_bus.ready;
         default: begin
            pop  = 1'b0;
            fire = 1'b0;
         end
      endcase
   end

   // step one: per-group free flags and lowest free slot in each group
   always_comb begin
      in_pad  = PAD_W'(in_map_ff);
      out_pad = PAD_W'(out_map_ff);
      limit   = (head_cmd.op == psia_pkg::OP_RES_PAIR) ? lim.npair : lim.nout;
      for (int i = 0; i < PAD_W; i++) begin
         free_vec[i] = !out_pad[i] && (psia_pkg::CNT_W'(i) < limit) &&
                       (head_cmd.op != psia_pkg::OP_RES_PAIR || !in_pad[i]);
      end
      for (int g = 0; g < NGRP; g++) begin
         grp_any_in[g]   = |free_vec[g*psia_pkg::GRP_W +: psia_pkg::GRP_W];
         grp_first_in[g] = '0;
         for (int j = psia_pkg::GRP_W - 1; j >= 0; j--) begin
            if (free_vec[g*psia_pkg::GRP_W + j]) begin
               grp_first_in[g] = psia_pkg::GRP_SEL_W'(j);
            end
         end
      end
   end

   // step two: pick the group, apply the command, form the result
   always_comb begin
      found = |grp_any_ff;
      sel_g = '0;
      for (int g = NGRP - 1; g >= 0; g--) begin
         if (grp_any_ff[g]) begin
            sel_g = GRP_IW'(g);
         end
      end
      grant_idx = {sel_g, grp_first_ff[sel_g]};
      mid       = IDX_W'(cmd_ff.id);

      in_map_in     = in_map_ff;
      out_map_in    = out_map_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_used_in   = rsp_used_ff;
      tag_we        = 1'b0;

      if (fire) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = psia_pkg::ST_OK;
         rsp_id_in     = cmd_ff.id;
         rsp_tag_in    = '0;
         rsp_used_in   = 1'b0;
         case (cmd_ff.op)
            psia_pkg::OP_RES_PAIR, psia_pkg::OP_RES_OUT: begin
               rsp_id_in = '0;
               if (found) begin
                  rsp_id_in             = psia_pkg::ID_W'(grant_idx);
                  out_map_in[grant_idx] = 1'b1;
                  if (cmd_ff.op == psia_pkg::OP_RES_PAIR) begin
                     in_map_in[grant_idx] = 1'b1;
                     tag_we               = int'(grant_idx) < TAG_DEPTH;
                  end
               end else begin
                  rsp_status_in = psia_pkg::ST_FULL;
               end
            end
            psia_pkg::OP_REL_PAIR: begin
               if (cmd_ff.range_err) begin
                  rsp_status_in = psia_pkg::ST_RANGE;
               end else begin
                  out_map_in[mid] = 1'b0;
                  in_map_in[mid]  = 1'b0;
                  rsp_tag_in      = in_map_ff[mid] ? tag_rd_data : '0;
               end
            end
            psia_pkg::OP_REL_OUT: begin
               if (cmd_ff.range_err) begin
                  rsp_status_in = psia_pkg::ST_RANGE;
               end else begin
                  out_map_in[mid] = 1'b0;
               end
            end
            psia_pkg::OP_QUERY: begin
               if (cmd_ff.range_err) begin
                  rsp_status_in = psia_pkg::ST_RANGE;
               end else begin
                  rsp_used_in = in_map_ff[mid];
               end
            end
            default: rsp_status_in = psia_pkg::ST_OK;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= psia_pkg::BK_IDLE;
         in_map_ff    <= '0;
         out_map_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_map_ff    <= in_map_in;
         out_map_ff   <= out_map_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cmd_ff       <= head_cmd;
         grp_any_ff   <= grp_any_in;
         grp_first_ff <= grp_first_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_used_ff   <= rsp_used_in;
   end

   psia_ram #(
      .WIDTH (psia_pkg::TAG_W),
      .DEPTH (TAG_DEPTH)
   ) u_tag_ram (
      .clock (clock),
      .we    (tag_we),
      .waddr (TAG_AW'(grant_idx)),
      .wdata (cmd_ff.tag),
      .re    (pop),
      .raddr (TAG_AW'(head_cmd.id)),
      .rdata (tag_rd_data)
   );

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.status     = rsp_status_ff;
   assign rsp_bus.granted_id = rsp_id_ff;
   assign rsp_bus.stored_tag = rsp_tag_ff;
   assign rsp_bus.in_use     = rsp_used_ff;

endmodule
`default_nettype wire

// ----- design/paired_stream_id_allocator.sv -----
// Top level of the paired stream ID allocator.
//
//   Channel   Dir   Handshake        Payload
//   req_bus   in    valid/ready      mode, stream_id, owner_tag
//   rsp_bus   out   valid/ready      status, granted_id, stored_tag, in_use
//   csr_*     in    csr_we strobe    csr_idx, csr_wdata
//
// The back end handles one item at a time in two steps (group-wise free search
// plus tag read, then group select and bitmap update).
// A taken request passes the command queue, step-one registers and result register.
// Reset clears both bitmaps at once and sets both counts to 64; no clearing pass.
// The two-entry command queue and the result register let either side stall.
`default_nettype none
`include "paired_stream_id_allocator_defines.svh"
module paired_stream_id_allocator #(
   parameter int MAX_STREAMS = 64
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   psia_req_if.sink                            req_bus,
   psia_rsp_if.source                          rsp_bus,
   input  wire logic                           csr_we,
   input  wire logic [psia_pkg::CSR_IDX_W-1:0] csr_idx,
   input  wire logic [psia_pkg::CNT_W-1:0]     csr_wdata
);

   localparam int CAP_MAX = (1 << psia_pkg::CNT_W) - 1;
   localparam logic [psia_pkg::CNT_W-1:0] COUNT_CAP =
      psia_pkg::CNT_W'((MAX_STREAMS < CAP_MAX) ? MAX_STREAMS : CAP_MAX);

   logic [psia_pkg::CNT_W-1:0] in_cnt_ff, in_cnt_in;
   logic [psia_pkg::CNT_W-1:0] out_cnt_ff, out_cnt_in;
   psia_pkg::limits_type       lim;

   logic              push;
   psia_pkg::cmd_type push_cmd;
   psia_pkg::cmd_type head_cmd;
   logic              q_full;
   logic              q_empty;
   logic              pop;

   always_comb begin
      in_cnt_in  = in_cnt_ff;
      out_cnt_in = out_cnt_ff;
      if (csr_we) begin
         case (csr_idx)
            psia_pkg::CSR_IN_COUNT:  in_cnt_in  = csr_wdata;
            psia_pkg::CSR_OUT_COUNT: out_cnt_in = csr_wdata;
            default: begin
               in_cnt_in  = in_cnt_ff;
               out_cnt_in = out_cnt_ff;
            end
         endcase
      end
      lim.nin   = (in_cnt_ff > COUNT_CAP) ? COUNT_CAP : in_cnt_ff;
      lim.nout  = (out_cnt_ff > COUNT_CAP) ? COUNT_CAP : out_cnt_ff;
      lim.npair = (lim.nin < lim.nout) ? lim.nin : lim.nout;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_cnt_ff  <= psia_pkg::CNT_RESET;
         out_cnt_ff <= psia_pkg::CNT_RESET;
      end else begin
         in_cnt_ff  <= in_cnt_in;
         out_cnt_ff <= out_cnt_in;
      end
   end

   psia_front u_front (
      .lim      (lim),
      .req_bus  (req_bus),
      .q_full   (q_full),
      .push     (push),
      .push_cmd (push_cmd)
   );

   psia_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .full     (q_full),
      .empty    (q_empty)
   );

   psia_back #(
      .MAX_STREAMS (MAX_STREAMS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .lim      (lim),
      .head_cmd (head_cmd),
      .q_empty  (q_empty),
      .pop      (pop),
      .rsp_bus  (rsp_bus)
   );

   `PSIA_ASSERT_NXT(a_push_lands, req_bus.valid && req_bus.ready, !q_empty, "taken item missing from queue")
   `PSIA_ASSERT_IMP(a_full_clean, rsp_bus.valid && rsp_bus.status == psia_pkg::ST_FULL, rsp_bus.granted_id == '0 && rsp_bus.stored_tag == '0 && !rsp_bus.in_use, "failed reserve carries data")
   `PSIA_ASSERT_IMP(a_query_clean, rsp_bus.valid && rsp_bus.in_use, rsp_bus.status == psia_pkg::ST_OK && rsp_bus.stored_tag == '0, "in_use set on a bad result")

endmodule
`default_nettype wire

// ----- verif/tb.sv -----
// Self-checking testbench for the paired stream ID allocator.
`default_nettype none
module tb;
   import psia_pkg::*;

   localparam int STREAMS      = 64;
   localparam int DRAIN_CYCLES = 6;
   localparam int STALL_LIMIT  = 1000;
   localparam int ITEMS_PER_SETTING = 50;

   localparam logic [MODE_W-1:0] MODE_RSVD5 = 3'd5;
   localparam logic [MODE_W-1:0] MODE_RSVD6 = 3'd6;
   localparam logic [MODE_W-1:0] MODE_RSVD7 = 3'd7;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     granted_id;
      logic [TAG_W-1:0]    stored_tag;
      logic                in_use;
   } alloc_rsp_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_idx;
   logic [CNT_W-1:0]     csr_wdata;

   psia_req_if req_bus();
   psia_rsp_if rsp_bus();

   paired_stream_id_allocator #(.MAX_STREAMS(STREAMS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_idx   (csr_idx),
      .csr_wdata (csr_wdata)
   );

   // shadow state of the allocator
   logic [CNT_W-1:0]   in_count;
   logic [CNT_W-1:0]   out_count;
   logic [STREAMS-1:0] in_map;
   logic [STREAMS-1:0] out_map;
   logic [TAG_W-1:0]   tag_mem [STREAMS];

   alloc_rsp_type expected_rsps[$];
   alloc_rsp_type want;

   int src_idle_pct;
   int snk_idle_pct;
   int errors;
   int items_taken;
   int rsps_seen;
   int n_full;
   int n_range;
   int n_settings;
   int stall_cycles;
   int sweep_pos;
   logic moved;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
   end

   function automatic int eff_count(input logic [CNT_W-1:0] c);
      return (int'(c) > STREAMS) ? STREAMS : int'(c);
   endfunction

   function automatic int pair_count();
      int a, b;
      a = eff_count(in_count);
      b = eff_count(out_count);
      return (a < b) ? a : b;
   endfunction

   function automatic alloc_rsp_type predict_alloc(input logic [MODE_W-1:0] mode,
                                                   input logic [ID_W-1:0] id,
                                                   input logic [TAG_W-1:0] tag);
      alloc_rsp_type r;
      int nin, nout, npair, i;
      logic found;
      nin = eff_count(in_count);
      nout = eff_count(out_count);
      npair = pair_count();
      found = 1'b0;
      r.status = ST_OK;
      r.granted_id = id;
      r.stored_tag = '0;
      r.in_use = 1'b0;
      case (mode)
         MODE_RES_PAIR: begin
            r.status = ST_FULL;
            r.granted_id = '0;
            for (i = 0; i < npair; i++) begin
               if (!found && !in_map[i] && !out_map[i]) begin
                  found = 1'b1;
                  in_map[i] = 1'b1;
                  out_map[i] = 1'b1;
                  tag_mem[i] = tag;
                  r.status = ST_OK;
                  r.granted_id = ID_W'(i);
               end
            end
         end
         MODE_RES_OUT: begin
            r.status = ST_FULL;
            r.granted_id = '0;
            for (i = 0; i < nout; i++) begin
               if (!found && !out_map[i]) begin
                  found = 1'b1;
                  out_map[i] = 1'b1;
                  r.status = ST_OK;
                  r.granted_id = ID_W'(i);
               end
            end
         end
         MODE_REL_PAIR, MODE_REL_OUT: begin
            if (int'(id) >= npair) begin
               r.status = ST_RANGE;
            end else begin
               out_map[id] = 1'b0;
               if (mode == MODE_REL_PAIR) begin
                  if (in_map[id]) r.stored_tag = tag_mem[id];
                  in_map[id] = 1'b0;
               end
            end
         end
         MODE_QUERY: begin
            if (int'(id) >= nin) r.status = ST_RANGE;
            else r.in_use = in_map[id];
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   // handshakes are sampled mid-cycle, where nothing is changing
   always @(negedge clock) begin
      if (!reset) begin
         moved = 1'b0;
         if (req_bus.valid && req_bus.ready) begin
            expected_rsps.push_back(predict_alloc(req_bus.mode, req_bus.stream_id,
                                                  req_bus.owner_tag));
            items_taken++;
            moved = 1'b1;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            moved = 1'b1;
            rsps_seen++;
            if (expected_rsps.size() == 0) begin
               $error("response item with nothing expected");
               errors++;
            end else begin
               want = expected_rsps.pop_front();
               if (want.status == ST_FULL) n_full++;
               if (want.status == ST_RANGE) n_range++;
               if (rsp_bus.status !== want.status) begin
                  $error("status expected %0d got %0d", want.status, rsp_bus.status);
                  errors++;
               end
               if (rsp_bus.granted_id !== want.granted_id) begin
                  $error("granted_id expected %0d got %0d", want.granted_id,
                         rsp_bus.granted_id);
                  errors++;
               end
               if (rsp_bus.stored_tag !== want.stored_tag) begin
                  $error("stored_tag expected %h got %h", want.stored_tag,
                         rsp_bus.stored_tag);
                  errors++;
               end
               if (rsp_bus.in_use !== want.in_use) begin
                  $error("in_use expected %0d got %0d", want.in_use, rsp_bus.in_use);
                  errors++;
               end
            end
         end
         if (moved) stall_cycles = 0;
         else stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $error("no handshake for %0d cycles", STALL_LIMIT);
            $display("FAIL");
            $finish;
         end
      end
   end

   task automatic send_item(input logic [MODE_W-1:0] mode, input logic [ID_W-1:0] id,
                            input logic [TAG_W-1:0] tag);
      while ($urandom_range(99) < src_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.mode <= mode;
      req_bus.stream_id <= id;
      req_bus.owner_tag <= tag;
      do @(negedge clock); while (!req_bus.ready);
      @(posedge clock);
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_counts(input logic [CNT_W-1:0] nin, input logic [CNT_W-1:0] nout);
      wait_idle();
      csr_we <= 1'b1;
      csr_idx <= CSR_IN_COUNT;
      csr_wdata <= nin;
      @(posedge clock);
      csr_idx <= CSR_OUT_COUNT;
      csr_wdata <= nout;
      @(posedge clock);
      csr_we <= 1'b0;
      in_count = nin;
      out_count = nout;
      n_settings++;
   endtask

   // random used ID below lim, or any ID when none is used
   function automatic logic [ID_W-1:0] pick_id(input logic [STREAMS-1:0] mask, input int lim);
      int start, k, j;
      if (lim > 0) begin
         start = $urandom_range(lim - 1);
         for (k = 0; k < lim; k++) begin
            j = (start + k) % lim;
            if (mask[j]) return ID_W'(j);
         end
      end
      return ID_W'($urandom_range(STREAMS - 1));
   endfunction

   task automatic send_random_item();
      logic [MODE_W-1:0] mode;
      logic [ID_W-1:0] id;
      int pick, npair;
      npair = pair_count();
      pick = $urandom_range(99);
      id = ID_W'($urandom_range(STREAMS - 1));
      if (pick < 30) begin
         mode = MODE_RES_PAIR;
      end else if (pick < 42) begin
         mode = MODE_RES_OUT;
      end else if (pick < 67) begin
         mode = MODE_REL_PAIR;
         if ($urandom_range(9) < 8) id = pick_id(in_map, npair);
      end else if (pick < 77) begin
         mode = MODE_REL_OUT;
         if ($urandom_range(9) < 7) id = pick_id(out_map, npair);
      end else if (pick < 92) begin
         mode = MODE_QUERY;
         if ($urandom_range(3) != 0) id = pick_id(in_map, eff_count(in_count));
      end else if (pick < 96) begin
         mode = MODE_W'($urandom_range(MODE_RSVD7, MODE_RSVD5));
      end else begin
         mode = MODE_W'($urandom_range(MODE_RSVD7));
      end
      send_item(mode, id, TAG_W'($urandom_range(16'hFFFF)));
   endtask

   task automatic test_directed_modes();
      send_item(MODE_QUERY, 6'd0, 16'h0000);
      send_item(MODE_QUERY, 6'd63, 16'hFFFF);
      send_item(MODE_RES_PAIR, 6'd63, 16'hFFFF);
      send_item(MODE_RES_PAIR, 6'd0, 16'h0000);
      send_item(MODE_RES_OUT, 6'd0, 16'h1234);
      send_item(MODE_RES_PAIR, 6'd21, 16'hA5A5);
      send_item(MODE_QUERY, 6'd2, 16'h0000);
      send_item(MODE_QUERY, 6'd3, 16'h0000);
      send_item(MODE_REL_PAIR, 6'd0, 16'h5A5A);
      send_item(MODE_REL_PAIR, 6'd0, 16'h0000);
      send_item(MODE_REL_OUT, 6'd2, 16'h0000);
      send_item(MODE_REL_OUT, 6'd1, 16'h0000);
      send_item(MODE_RES_OUT, 6'd0, 16'h0000);
      send_item(MODE_RES_PAIR, 6'd0, 16'hC3C3);
      send_item(MODE_REL_PAIR, 6'd1, 16'h0000);
      send_item(MODE_REL_PAIR, 6'd40, 16'h0000);
      send_item(MODE_RSVD5, 6'd63, 16'hFFFF);
      send_item(MODE_RSVD6, 6'd42, 16'h0F0F);
      send_item(MODE_RSVD7, 6'd21, 16'hF0F0);
   endtask

   task automatic test_count_limits();
      set_counts(7'd0, 7'd64);
      send_item(MODE_RES_PAIR, 6'd0, 16'hBEEF);
      send_item(MODE_QUERY, 6'd5, 16'h0000);
      send_item(MODE_REL_PAIR, 6'd0, 16'h0000);
      set_counts(7'd64, 7'd0);
      send_item(MODE_RES_OUT, 6'd0, 16'h0000);
      send_item(MODE_REL_OUT, 6'd63, 16'h0000);
      set_counts(7'd127, 7'd127);
      send_item(MODE_QUERY, 6'd63, 16'h0000);
      set_counts(7'd2, 7'd1);
      send_item(MODE_QUERY, 6'd1, 16'h0000);
      send_item(MODE_RES_PAIR, 6'd0, 16'h7777);
   endtask

   task automatic test_random_traffic(input int src_pct, input int snk_pct);
      logic [2*CNT_W-1:0] setting;
      int s, n;
      src_idle_pct = src_pct;
      snk_idle_pct = snk_pct;
      for (s = 0; s < 3; s++) begin
         case (sweep_pos % 9)
            0: setting = {7'd64, 7'd64};
            1: setting = {7'd4, 7'd4};
            2: setting = {7'd3, 7'd9};
            3: setting = {7'd9, 7'd3};
            4: setting = {7'd1, 7'd1};
            5: setting = {7'd127, 7'd100};
            6: setting = {7'd16, 7'd16};
            7: setting = {7'd2, 7'd64};
            default: setting = {7'd64, 7'd64};
         endcase
         sweep_pos++;
         set_counts(setting[2*CNT_W-1:CNT_W], setting[CNT_W-1:0]);
         for (n = 0; n < ITEMS_PER_SETTING; n++) send_random_item();
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_idx = CSR_IN_COUNT;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.mode = MODE_RES_PAIR;
      req_bus.stream_id = '0;
      req_bus.owner_tag = '0;
      rsp_bus.ready = 1'b0;
      in_count = CNT_RESET;
      out_count = CNT_RESET;
      in_map = '0;
      out_map = '0;
      errors = 0;
      items_taken = 0;
      rsps_seen = 0;
      n_full = 0;
      n_range = 0;
      n_settings = 0;
      stall_cycles = 0;
      sweep_pos = 0;
      src_idle_pct = 8;
      snk_idle_pct = 63;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_modes();
      test_count_limits();
      test_random_traffic(8, 63);
      test_random_traffic(63, 8);
      test_random_traffic(0, 0);
      wait_idle();
      $display("Sent %0d items and checked %0d responses over %0d count settings.",
               items_taken, rsps_seen, n_settings);
      $display("Saw %0d full-map rejects and %0d out-of-range rejects.", n_full, n_range);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
`default_nettype wire
